### rtl/core/amct_pkg.sv
// Package: shared types and constants for the assignment matrix constraint tracker.
`timescale 1ns / 1ps

package amct_pkg;

  localparam int DEF_MAX_ROOMS  = 16;
  localparam int DEF_MAX_GROUPS = 16;

  localparam int VAL_W   = 12;
  localparam int IDX_W   = 4;
  localparam int CNT_W   = 5;
  localparam int REG_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
  localparam logic [REG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROOMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_GROUPS = 2'd1;

  typedef enum logic [1:0] {
    OP_SET_CAP = 2'd0,
    OP_SET_TGT = 2'd1,
    OP_WR_CELL = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [IDX_W-1:0] group_index;
    logic [IDX_W-1:0] room_index;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] rooms_over;
    logic [CNT_W-1:0] groups_wrong;
    logic [VAL_W-1:0] k_level;
    logic             k_valid;
  } out_item_t;

endpackage

### rtl/core/assignment_matrix_constraint_tracker_unit.sv
// Top level: assignment matrix constraint tracker with sequenced scan over cell memory.
`timescale 1ns / 1ps

// Usage:
//   in_valid/in_stall/in_data carry one command beat (set capacity, set target,
//   write cell, clear). out_valid/out_stall/out_data return one result beat per
//   command: rooms over capacity, groups off target, smallest nonzero cell.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write active_rooms (index 0) and
//   active_groups (index 1); write only while no command is in flight.
//   One command at a time. After the accept the command is applied (a cell
//   write reads the old amount and both totals before updating them), then
//   every cell is scanned and the result registered; a clear first runs a
//   clearing pass. The next command can be taken in the same cycle the result
//   appears. The cost is the cell memory's single read port, read once per
//   cycle by the scan sequencer that also walks room and group memories.
//   Reset: rst_n is synchronous, active low. After reset a clearing pass over
//   every cell zeroes cells, totals, capacities and targets; in_stall stays
//   high meanwhile, config writes are still taken.
//   Output stall: the result is held in an output register; the next command
//   is accepted while it waits, and its own result waits until the port frees.
module assignment_matrix_constraint_tracker_unit #(
  parameter int MAX_ROOMS  = amct_pkg::DEF_MAX_ROOMS,
  parameter int MAX_GROUPS = amct_pkg::DEF_MAX_GROUPS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  amct_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output amct_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [amct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amct_pkg::REG_W-1:0]          cfg_data
);

  localparam int NCELL = MAX_ROOMS * MAX_GROUPS;
  localparam int CAW   = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int RAW   = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int GAW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int MAXRG = (MAX_ROOMS > MAX_GROUPS) ? MAX_ROOMS : MAX_GROUPS;
  localparam int TW    = amct_pkg::VAL_W + ((MAXRG > 1) ? $clog2(MAXRG) : 0);
  localparam int CMPW  = (CAW + 1 > 7) ? CAW + 1 : 7;
  localparam int VW    = amct_pkg::VAL_W;
  localparam int CW    = amct_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY,
    ST_MODIFY,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Memories
  logic [VW-1:0] cell_mem [NCELL];
  logic [TW-1:0] rtot_mem [MAX_ROOMS];
  logic [TW-1:0] gtot_mem [MAX_GROUPS];
  logic [VW-1:0] cap_mem  [MAX_ROOMS];
  logic [VW-1:0] tgt_mem  [MAX_GROUPS];

  logic [VW-1:0] cell_q;
  logic [TW-1:0] rtot_q;
  logic [TW-1:0] gtot_q;
  logic [VW-1:0] cap_q;
  logic [VW-1:0] tgt_q;

  // Control registers
  state_t              state_r, state_nxt;
  logic                clr_all_r, clr_all_nxt;
  logic [CAW-1:0]      cnt_r, cnt_nxt;
  logic                pv_r, pv_nxt;
  logic [CAW-1:0]      pidx_r, pidx_nxt;
  amct_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       over_r, over_nxt;
  logic [CW-1:0]       wrong_r, wrong_nxt;
  logic [VW-1:0]       kmin_r, kmin_nxt;
  logic                kfound_r, kfound_nxt;
  logic                out_valid_r, out_valid_nxt;
  amct_pkg::out_item_t out_data_r, out_data_nxt;
  logic [amct_pkg::REG_W-1:0] act_rooms_r, act_rooms_nxt;
  logic [amct_pkg::REG_W-1:0] act_groups_r, act_groups_nxt;

  // Effective counts and address decode
  logic [CMPW-1:0] nr_eff, ng_eff;
  logic            in_room_ok, in_grp_ok;
  logic [CAW-1:0]  item_cidx;
  logic [RAW-1:0]  item_raddr;
  logic [GAW-1:0]  item_gaddr;
  logic            cnt_in_rooms, cnt_in_grps;
  logic [RAW-1:0]  cnt_raddr;
  logic [GAW-1:0]  cnt_gaddr;
  logic            cnt_last;
  logic            p_room_ok, p_grp_ok;

  // Memory port controls
  logic           cell_we;
  logic [CAW-1:0] cell_waddr, cell_raddr;
  logic [VW-1:0]  cell_wdata;
  logic           rtot_we;
  logic [RAW-1:0] rtot_waddr, rtot_raddr;
  logic [TW-1:0]  rtot_wdata;
  logic           gtot_we;
  logic [GAW-1:0] gtot_waddr, gtot_raddr;
  logic [TW-1:0]  gtot_wdata;
  logic           cap_we;
  logic [RAW-1:0] cap_waddr;
  logic [VW-1:0]  cap_wdata;
  logic           tgt_we;
  logic [GAW-1:0] tgt_waddr;
  logic [VW-1:0]  tgt_wdata;

  assign nr_eff = (CMPW'(act_rooms_r) > CMPW'(MAX_ROOMS)) ? CMPW'(MAX_ROOMS)
                                                          : CMPW'(act_rooms_r);
  assign ng_eff = (CMPW'(act_groups_r) > CMPW'(MAX_GROUPS)) ? CMPW'(MAX_GROUPS)
                                                            : CMPW'(act_groups_r);

  assign in_room_ok = CMPW'(item_r.room_index) < nr_eff;
  assign in_grp_ok  = CMPW'(item_r.group_index) < ng_eff;
  assign item_cidx  = CAW'(32'(item_r.group_index) * 32'(MAX_ROOMS)
                           + 32'(item_r.room_index));
  assign item_raddr = RAW'(item_r.room_index);
  assign item_gaddr = GAW'(item_r.group_index);

  assign cnt_in_rooms = CMPW'(cnt_r) < CMPW'(MAX_ROOMS);
  assign cnt_in_grps  = CMPW'(cnt_r) < CMPW'(MAX_GROUPS);
  assign cnt_raddr    = cnt_in_rooms ? cnt_r[RAW-1:0] : '0;
  assign cnt_gaddr    = cnt_in_grps ? cnt_r[GAW-1:0] : '0;
  assign cnt_last     = cnt_r == CAW'(NCELL - 1);

  assign p_room_ok = CMPW'(pidx_r) < nr_eff;
  assign p_grp_ok  = CMPW'(pidx_r) < ng_eff;

  assign in_stall  = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory write and read selection
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cnt_r;
    cell_wdata = '0;
    rtot_we    = 1'b0;
    rtot_waddr = cnt_raddr;
    rtot_wdata = '0;
    gtot_we    = 1'b0;
    gtot_waddr = cnt_gaddr;
    gtot_wdata = '0;
    cap_we     = 1'b0;
    cap_waddr  = cnt_raddr;
    cap_wdata  = '0;
    tgt_we     = 1'b0;
    tgt_waddr  = cnt_gaddr;
    tgt_wdata  = '0;
    cell_raddr = cnt_r;
    rtot_raddr = cnt_raddr;
    gtot_raddr = cnt_gaddr;
    case (state_r)
      ST_CLEAR: begin
        cell_we = 1'b1;
        rtot_we = cnt_in_rooms;
        gtot_we = cnt_in_grps;
        cap_we  = clr_all_r && cnt_in_rooms;
        tgt_we  = clr_all_r && cnt_in_grps;
      end
      ST_APPLY: begin
        cell_raddr = item_cidx;
        rtot_raddr = item_raddr;
        gtot_raddr = item_gaddr;
        cap_waddr  = item_raddr;
        cap_wdata  = item_r.value;
        tgt_waddr  = item_gaddr;
        tgt_wdata  = item_r.value;
        cap_we     = (item_r.operation == amct_pkg::OP_SET_CAP) && in_room_ok;
        tgt_we     = (item_r.operation == amct_pkg::OP_SET_TGT) && in_grp_ok;
      end
      ST_MODIFY: begin
        // old amount leaves both totals, new amount enters
        cell_we    = 1'b1;
        cell_waddr = item_cidx;
        cell_wdata = item_r.value;
        rtot_we    = 1'b1;
        rtot_waddr = item_raddr;
        rtot_wdata = rtot_q - TW'(cell_q) + TW'(item_r.value);
        gtot_we    = 1'b1;
        gtot_waddr = item_gaddr;
        gtot_wdata = gtot_q - TW'(cell_q) + TW'(item_r.value);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    cell_q <= cell_mem[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (rtot_we) begin
      rtot_mem[rtot_waddr] <= rtot_wdata;
    end
    rtot_q <= rtot_mem[rtot_raddr];
  end

  always_ff @(posedge clk) begin
    if (gtot_we) begin
      gtot_mem[gtot_waddr] <= gtot_wdata;
    end
    gtot_q <= gtot_mem[gtot_raddr];
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_mem[cap_waddr] <= cap_wdata;
    end
    cap_q <= cap_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    tgt_q <= tgt_mem[cnt_gaddr];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_all_nxt    = clr_all_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    item_nxt       = item_r;
    over_nxt       = over_r;
    wrong_nxt      = wrong_r;
    kmin_nxt       = kmin_r;
    kfound_nxt     = kfound_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    act_rooms_nxt  = act_rooms_r;
    act_groups_nxt = act_groups_r;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == amct_pkg::REG_ACTIVE_ROOMS) begin
        act_rooms_nxt = cfg_data;
      end else if (cfg_index == amct_pkg::REG_ACTIVE_GROUPS) begin
        act_groups_nxt = cfg_data;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // fold the element read in the previous cycle
    if (pv_r) begin
      if (p_room_ok && (rtot_q > TW'(cap_q)) && (over_r != amct_pkg::CNT_MAX)) begin
        over_nxt = over_r + 1'b1;
      end
      if (p_grp_ok && (gtot_q != TW'(tgt_q)) && (wrong_r != amct_pkg::CNT_MAX)) begin
        wrong_nxt = wrong_r + 1'b1;
      end
      if ((cell_q != '0) && (!kfound_r || (cell_q < kmin_r))) begin
        kmin_nxt   = cell_q;
        kfound_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt     = '0;
          clr_all_nxt = 1'b0;
          state_nxt   = clr_all_r ? ST_IDLE : ST_SCAN;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cnt_nxt = '0;
        case (item_r.operation)
          amct_pkg::OP_WR_CELL: begin
            state_nxt = (in_room_ok && in_grp_ok) ? ST_MODIFY : ST_SCAN;
          end
          amct_pkg::OP_CLEAR: begin
            state_nxt = ST_CLEAR;
          end
          default: begin
            state_nxt = ST_SCAN;
          end
        endcase
      end
      ST_MODIFY: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_r;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.rooms_over   = over_r;
          out_data_nxt.groups_wrong = wrong_r;
          out_data_nxt.k_level      = kfound_r ? kmin_r : '0;
          out_data_nxt.k_valid      = kfound_r;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // start every scan with empty accumulators
    if (state_r != ST_SCAN && state_r != ST_DRAIN) begin
      over_nxt   = '0;
      wrong_nxt  = '0;
      kmin_nxt   = '0;
      kfound_nxt = 1'b0;
    end
    if (state_r == ST_FINISH) begin
      over_nxt   = over_r;
      wrong_nxt  = wrong_r;
      kmin_nxt   = kmin_r;
      kfound_nxt = kfound_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_all_r    <= 1'b1;
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      act_rooms_r  <= amct_pkg::ACTIVE_RESET;
      act_groups_r <= amct_pkg::ACTIVE_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_all_r    <= clr_all_nxt;
      cnt_r        <= cnt_nxt;
      pv_r         <= pv_nxt;
      out_valid_r  <= out_valid_nxt;
      act_rooms_r  <= act_rooms_nxt;
      act_groups_r <= act_groups_nxt;
    end
    pidx_r     <= pidx_nxt;
    item_r     <= item_nxt;
    over_r     <= over_nxt;
    wrong_r    <= wrong_nxt;
    kmin_r     <= kmin_nxt;
    kfound_r   <= kfound_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### test/tb_assignment_matrix_constraint_tracker_unit.sv
// Self-checking testbench for the assignment matrix constraint tracker top level.
`timescale 1ns / 1ps

module tb_assignment_matrix_constraint_tracker_unit;

  localparam int ROOMS          = amct_pkg::DEF_MAX_ROOMS;
  localparam int GROUPS         = amct_pkg::DEF_MAX_GROUPS;
  localparam int CELLS          = ROOMS * GROUPS;
  localparam int HOLD_LEN       = 3000;
  localparam int TAIL_CYCLES    = 2 * CELLS + 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SWEEP_ITEMS    = 45;

  // register indexes with no register behind them
  localparam logic [amct_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [amct_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  amct_pkg::in_item_t             in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  amct_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [amct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [amct_pkg::REG_W-1:0]     cfg_data  = '0;

  assignment_matrix_constraint_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // tracker state as the testbench sees it
  logic [amct_pkg::REG_W-1:0] rooms_reg;
  logic [amct_pkg::REG_W-1:0] groups_reg;
  logic [amct_pkg::VAL_W-1:0] cell_amt  [CELLS];
  logic [15:0]                room_sum  [ROOMS];
  logic [15:0]                group_sum [GROUPS];
  logic [amct_pkg::VAL_W-1:0] room_cap  [ROOMS];
  logic [amct_pkg::VAL_W-1:0] group_tgt [GROUPS];

  amct_pkg::out_item_t pending_results[$];
  amct_pkg::out_item_t want;
  int        fail_count      = 0;
  int        cmds_sent       = 0;
  int        results_checked = 0;
  int        settings_used   = 0;
  bit        idle_en         = 1'b1;
  int        hold_ask        = 0;
  int        hold_seen       = 0;
  int        hold_left       = 0;
  int        stall_burst     = 0;
  int        quiet_cycles    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_rooms();
    return (rooms_reg > ROOMS) ? ROOMS : int'(rooms_reg);
  endfunction

  function automatic int eff_groups();
    return (groups_reg > GROUPS) ? GROUPS : int'(groups_reg);
  endfunction

  function automatic void clear_matrix();
    for (int i = 0; i < CELLS; i++) cell_amt[i] = '0;
    for (int i = 0; i < ROOMS; i++) room_sum[i] = '0;
    for (int i = 0; i < GROUPS; i++) group_sum[i] = '0;
  endfunction

  function automatic void reset_tracker();
    rooms_reg  = amct_pkg::ACTIVE_RESET;
    groups_reg = amct_pkg::ACTIVE_RESET;
    clear_matrix();
    for (int i = 0; i < ROOMS; i++) room_cap[i] = '0;
    for (int i = 0; i < GROUPS; i++) group_tgt[i] = '0;
  endfunction

  // Apply one command to the tracker state and return the answer it yields.
  function automatic amct_pkg::out_item_t track_command(amct_pkg::in_item_t cmd);
    int                         nr;
    int                         ng;
    int                         idx;
    bit                         found;
    logic [amct_pkg::VAL_W-1:0] old;
    amct_pkg::out_item_t        res;
    nr    = eff_rooms();
    ng    = eff_groups();
    res   = '0;
    found = 1'b0;
    case (cmd.operation)
      amct_pkg::OP_SET_CAP: begin
        if (cmd.room_index < nr) room_cap[cmd.room_index] = cmd.value;
      end
      amct_pkg::OP_SET_TGT: begin
        if (cmd.group_index < ng) group_tgt[cmd.group_index] = cmd.value;
      end
      amct_pkg::OP_WR_CELL: begin
        if (cmd.room_index < nr && cmd.group_index < ng) begin
          idx = int'(cmd.group_index) * ROOMS + int'(cmd.room_index);
          old = cell_amt[idx];
          cell_amt[idx] = cmd.value;
          room_sum[cmd.room_index]   = room_sum[cmd.room_index] - 16'(old)
                                       + 16'(cmd.value);
          group_sum[cmd.group_index] = group_sum[cmd.group_index] - 16'(old)
                                       + 16'(cmd.value);
        end
      end
      amct_pkg::OP_CLEAR: begin
        clear_matrix();
      end
      default: begin
      end
    endcase
    for (int i = 0; i < nr; i++)
      if (room_sum[i] > 16'(room_cap[i]) && res.rooms_over < amct_pkg::CNT_MAX)
        res.rooms_over++;
    for (int i = 0; i < ng; i++)
      if (group_sum[i] != 16'(group_tgt[i]) && res.groups_wrong < amct_pkg::CNT_MAX)
        res.groups_wrong++;
    // scan every cell, including ones left outside the active area
    for (int i = 0; i < CELLS; i++) begin
      if (cell_amt[i] != '0 && (!found || cell_amt[i] < res.k_level)) begin
        res.k_level = cell_amt[i];
        found = 1'b1;
      end
    end
    res.k_valid = found;
    return res;
  endfunction

  function automatic amct_pkg::in_item_t make_cmd(amct_pkg::op_t op,
                                                  logic [amct_pkg::IDX_W-1:0] grp,
                                                  logic [amct_pkg::IDX_W-1:0] room,
                                                  logic [amct_pkg::VAL_W-1:0] amount);
    amct_pkg::in_item_t cmd;
    cmd.operation   = op;
    cmd.group_index = grp;
    cmd.room_index  = room;
    cmd.value       = amount;
    return cmd;
  endfunction

  // Mostly inside the active range, sometimes anywhere.
  function automatic logic [amct_pkg::IDX_W-1:0] pick_index(int active);
    if (active > 0 && $urandom_range(0, 3) != 0)
      return amct_pkg::IDX_W'($urandom_range(0, active - 1));
    return amct_pkg::IDX_W'($urandom_range(0, (1 << amct_pkg::IDX_W) - 1));
  endfunction

  function automatic logic [amct_pkg::VAL_W-1:0] pick_amount();
    int pick;
    pick = int'($urandom_range(0, 19));
    if (pick < 3) return '0;
    if (pick < 5) return '1;
    if (pick < 8) return amct_pkg::VAL_W'($urandom_range(0, (1 << amct_pkg::VAL_W) - 1));
    return amct_pkg::VAL_W'($urandom_range(1, 64));
  endfunction

  // Build a command; capacities and targets often land on or near the live totals.
  function automatic amct_pkg::in_item_t random_command();
    amct_pkg::in_item_t cmd;
    int                 pick;
    int                 near;
    pick = int'($urandom_range(0, 99));
    cmd  = make_cmd(amct_pkg::OP_WR_CELL, pick_index(eff_groups()), pick_index(eff_rooms()),
                    pick_amount());
    if (pick < 45) begin
      cmd.operation = amct_pkg::OP_WR_CELL;
    end else if (pick < 65) begin
      cmd.operation = amct_pkg::OP_SET_CAP;
      if ($urandom_range(0, 1) == 1) begin
        near = int'(room_sum[cmd.room_index]) + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > (1 << amct_pkg::VAL_W) - 1) near = (1 << amct_pkg::VAL_W) - 1;
        cmd.value = amct_pkg::VAL_W'(near);
      end
    end else if (pick < 85) begin
      cmd.operation = amct_pkg::OP_SET_TGT;
      if ($urandom_range(0, 1) == 1 &&
          int'(group_sum[cmd.group_index]) < (1 << amct_pkg::VAL_W))
        cmd.value = amct_pkg::VAL_W'(group_sum[cmd.group_index]);
    end else if (pick < 90) begin
      cmd.operation = amct_pkg::OP_CLEAR;
    end else begin
      cmd = make_cmd(amct_pkg::op_t'($urandom_range(0, 3)),
                     amct_pkg::IDX_W'($urandom_range(0, (1 << amct_pkg::IDX_W) - 1)),
                     amct_pkg::IDX_W'($urandom_range(0, (1 << amct_pkg::IDX_W) - 1)),
                     amct_pkg::VAL_W'($urandom_range(0, (1 << amct_pkg::VAL_W) - 1)));
    end
    return cmd;
  endfunction

  // Offer one command beat and record its expected answer once taken.
  task automatic send_command(input amct_pkg::in_item_t cmd);
    amct_pkg::out_item_t exp_res;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall !== 1'b0);
    exp_res = track_command(cmd);
    pending_results = {pending_results, exp_res};
    cmds_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [amct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [amct_pkg::REG_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == amct_pkg::REG_ACTIVE_ROOMS) rooms_reg = data;
    else if (idx == amct_pkg::REG_ACTIVE_GROUPS) groups_reg = data;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [amct_pkg::REG_W-1:0] rooms,
                               input logic [amct_pkg::REG_W-1:0] groups);
    wait_drained();
    write_reg(amct_pkg::REG_ACTIVE_ROOMS, rooms, 1'b0);
    write_reg(amct_pkg::REG_ACTIVE_GROUPS, groups, 1'b1);
    settings_used++;
  endtask

  task automatic test_directed();
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd15, 4'd15, 12'hFFF));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd0, 4'd0, 12'h001));
    send_command(make_cmd(amct_pkg::OP_SET_CAP, 4'd0, 4'd15, 12'hFFF));
    send_command(make_cmd(amct_pkg::OP_SET_CAP, 4'd15, 4'd0, 12'h001));
    send_command(make_cmd(amct_pkg::OP_SET_TGT, 4'd15, 4'd0, 12'hFFF));
    send_command(make_cmd(amct_pkg::OP_SET_TGT, 4'd0, 4'd15, 12'h001));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd0, 4'd0, 12'h000));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd10, 4'd5, 12'hAAA));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd5, 4'd10, 12'h555));
    send_command(make_cmd(amct_pkg::OP_CLEAR, 4'd7, 4'd9, 12'h123));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd3, 4'd3, 12'h000));
    // this cell is stranded once the active area shrinks
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd12, 4'd12, 12'h009));
    apply_setting(5'd4, 5'd3);
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd2, 4'd3, 12'h00A));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd3, 4'd1, 12'h001));
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd1, 4'd4, 12'h001));
    send_command(make_cmd(amct_pkg::OP_SET_CAP, 4'd0, 4'd4, 12'h000));
    send_command(make_cmd(amct_pkg::OP_SET_TGT, 4'd3, 4'd0, 12'h000));
    send_command(make_cmd(amct_pkg::OP_SET_CAP, 4'd0, 4'd3, 12'h00A));
    apply_setting(5'd0, 5'd0);
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd0, 4'd0, 12'h005));
    send_command(make_cmd(amct_pkg::OP_SET_CAP, 4'd0, 4'd0, 12'h000));
    // oversized register values saturate
    apply_setting(5'd31, 5'd31);
    send_command(make_cmd(amct_pkg::OP_WR_CELL, 4'd15, 4'd15, 12'h002));
    wait_drained();
    write_reg(REG_SPARE_2, 5'd1, 1'b0);
    write_reg(REG_SPARE_3, 5'd0, 1'b1);
    send_command(make_cmd(amct_pkg::OP_SET_TGT, 4'd15, 4'd15, 12'h002));
    send_command(make_cmd(amct_pkg::OP_CLEAR, 4'd15, 4'd15, 12'hFFF));
  endtask

  task automatic test_register_sweep();
    logic [amct_pkg::REG_W-1:0] rooms;
    logic [amct_pkg::REG_W-1:0] groups;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin rooms = 5'd1;  groups = 5'd1;  end
        1: begin rooms = 5'd16; groups = 5'd1;  end
        2: begin rooms = 5'd1;  groups = 5'd16; end
        3: begin rooms = 5'd0;  groups = 5'd16; end
        4: begin rooms = 5'd16; groups = 5'd0;  end
        5: begin rooms = 5'd31; groups = 5'd20; end
        default: begin
          rooms  = amct_pkg::REG_W'($urandom_range(0, 31));
          groups = amct_pkg::REG_W'($urandom_range(0, 31));
        end
      endcase
      apply_setting(rooms, groups);
      repeat (SWEEP_ITEMS) send_command(random_command());
    end
  endtask

  task automatic test_pressure();
    apply_setting(5'd16, 5'd16);
    // long receiver hold-off while commands keep coming
    hold_ask++;
    repeat (8) send_command(random_command());
    repeat (4) send_command(random_command());
    // sender pause until everything has drained
    wait_drained();
    repeat (6) send_command(random_command());
  endtask

  task automatic test_final_stretch();
    idle_en = 1'b0;
    apply_setting(amct_pkg::REG_W'($urandom_range(1, 16)),
                  amct_pkg::REG_W'($urandom_range(1, 16)));
    repeat (40) send_command(random_command());
  endtask

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_burst != 0) begin
      stall_burst <= stall_burst - 1;
      out_stall   <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_burst <= int'($urandom_range(0, 3));
      out_stall   <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command pending: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_data.rooms_over !== want.rooms_over) begin
          $error("rooms_over: expected %0d, got %0d", want.rooms_over, out_data.rooms_over);
          fail_count++;
        end
        if (out_data.groups_wrong !== want.groups_wrong) begin
          $error("groups_wrong: expected %0d, got %0d", want.groups_wrong,
                 out_data.groups_wrong);
          fail_count++;
        end
        if (out_data.k_level !== want.k_level) begin
          $error("k_level: expected %0d, got %0d", want.k_level, out_data.k_level);
          fail_count++;
        end
        if (out_data.k_valid !== want.k_valid) begin
          $error("k_valid: expected %0d, got %0d", want.k_valid, out_data.k_valid);
          fail_count++;
        end
      end
    end
  end

  // end the run if nothing moves on any port for too long
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no beat for %0d cycles, %0d results outstanding",
             quiet_cycles, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_sweep();
    test_pressure();
    test_final_stretch();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d commands, checked %0d result beats, %0d register settings.",
             cmds_sent, results_checked, settings_used);
    $display("Run included out-of-range indexes, empty and saturated areas, and back-pressure.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
